>>> hw/rtl/dsf_pkg.sv
// Package for the DShot frame encoder: word types, config struct, constants.
// No dependencies.
package dsf_pkg;

   localparam int ThrW   = 11;
   localparam int PulseW = 16;
   localparam int FrameW = 16;
   localparam int SlotW  = 5;
   localparam int CsrIdxW = 3;

   localparam logic [ThrW-1:0]  THROTTLE_LIMIT = 11'd2000;
   localparam logic [ThrW:0]    VALUE_OFFSET   = 12'd47;
   localparam logic [ThrW-1:0]  VALUE_MAX      = 11'd2047;
   localparam logic [SlotW-1:0] FRAME_BITS     = 5'd16;
   localparam logic [SlotW-1:0] SLOT_LAST      = 5'd17;

   localparam logic ACT_SET  = 1'b0;
   localparam logic ACT_SEND = 1'b1;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_PULSE  = 1'b1;

   localparam logic ST_OK     = 1'b0;
   localparam logic ST_REJECT = 1'b1;

   localparam logic [CsrIdxW-1:0] CSR_IDLE_FLOOR  = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_THR_CEILING = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_IDLE_SPIN   = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_TELEMETRY   = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_PULSE_HIGH  = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_PULSE_LOW   = 3'd5;

   typedef struct packed {
      logic            action;
      logic [ThrW-1:0] throttle;
      logic            armed;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic              status;
      logic [PulseW-1:0] pulse_width;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [ThrW-1:0]   idle_floor;
      logic [ThrW-1:0]   throttle_ceiling;
      logic              idle_spin_mode;
      logic              telemetry_request;
      logic [PulseW-1:0] pulse_high;
      logic [PulseW-1:0] pulse_low;
   } cfg_type;

   // Job handed from the mapper to the emitter.
   typedef struct packed {
      logic              is_frame;
      logic              status;
      logic [FrameW-1:0] frame;
   } job_type;

endpackage

>>> hw/rtl/dsf_mapper.sv
// Throttle check and mapping, held value register and frame/checksum build.
// Depends on dsf_pkg.
module dsf_mapper
   import dsf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  req_type item,
   input  logic    advance,
   output job_type job
);

   logic [ThrW-1:0] held_ff, held_in;
   logic            thr_ok;
   logic [ThrW-1:0] lo_clamp, hi_clamp, val_sat, mapped;
   logic [ThrW:0]   val_sum;
   logic [ThrW:0]   pkt;
   logic [3:0]      csum;

   always_comb begin
      thr_ok   = item.throttle <= THROTTLE_LIMIT;
      lo_clamp = (item.throttle < cfg.idle_floor) ? cfg.idle_floor : item.throttle;
      hi_clamp = (lo_clamp > cfg.throttle_ceiling) ? cfg.throttle_ceiling : lo_clamp;
      val_sum  = {1'b0, hi_clamp} + VALUE_OFFSET;
      val_sat  = val_sum[ThrW] ? VALUE_MAX : val_sum[ThrW-1:0];
      if (!item.armed) begin
         mapped = '0;
      end else if (item.throttle == '0 && !cfg.idle_spin_mode) begin
         mapped = '0;
      end else begin
         mapped = val_sat;
      end

      held_in = held_ff;
      if (advance && item.action == ACT_SET && thr_ok) begin
         held_in = mapped;
      end

      pkt  = {held_ff, cfg.telemetry_request};
      csum = pkt[3:0] ^ pkt[7:4] ^ pkt[11:8];

      job.is_frame = item.action == ACT_SEND;
      job.status   = (item.action == ACT_SET && !thr_ok) ? ST_REJECT : ST_OK;
      job.frame    = {pkt, csum};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

endmodule

>>> hw/rtl/dsf_emitter.sv
// Result sequencer: status word or 18 pulse-width slots, output register.
// Depends on dsf_pkg.
module dsf_emitter
   import dsf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  job_type job,
   input  logic    job_valid,
   output logic    can_load,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   logic              busy_ff, busy_in;
   logic              is_frame_ff, is_frame_in;
   logic              status_ff, status_in;
   logic [FrameW-1:0] frame_ff, frame_in;
   logic [SlotW-1:0]  slot_ff, slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              out_ok, emit, last_slot;
   rsp_type           word;

   always_comb begin
      out_ok    = !rsp_valid_ff || !rsp_stall;
      emit      = busy_ff && out_ok;
      last_slot = !is_frame_ff || slot_ff == SLOT_LAST;
      can_load  = !busy_ff || (emit && last_slot);

      if (is_frame_ff) begin
         word.kind        = KIND_PULSE;
         word.status      = ST_OK;
         word.pulse_width = (slot_ff < FRAME_BITS)
                            ? (frame_ff[FrameW-1] ? cfg.pulse_high : cfg.pulse_low)
                            : '0;
         word.last        = slot_ff == SLOT_LAST;
      end else begin
         word.kind        = KIND_STATUS;
         word.status      = status_ff;
         word.pulse_width = '0;
         word.last        = 1'b1;
      end

      busy_in      = busy_ff;
      is_frame_in  = is_frame_ff;
      status_in    = status_ff;
      frame_in     = frame_ff;
      slot_in      = slot_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (emit) begin
         rsp_in       = word;
         rsp_valid_in = 1'b1;
         frame_in     = {frame_ff[FrameW-2:0], 1'b0};
         if (last_slot) begin
            busy_in = 1'b0;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
      if (job_valid && can_load) begin
         busy_in     = 1'b1;
         is_frame_in = job.is_frame;
         status_in   = job.status;
         frame_in    = job.frame;
         slot_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         slot_ff      <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
      end
      is_frame_ff <= is_frame_in;
      status_ff   <= status_in;
      frame_ff    <= frame_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef SYNTHESIS
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_LAST)
      else $error("slot counter past last slot");
   a_status_single: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !is_frame_ff |-> slot_ff == '0)
      else $error("status job ran more than one slot");
   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      busy_ff && emit && last_slot |=> rsp_valid_ff && rsp_ff.last)
      else $error("job finished without last word");
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !emit |-> !can_load)
      else $error("load while job in progress");
`endif

endmodule

>>> hw/rtl/dshot_frame_encoder.sv
// Top level of the DShot frame encoder: config registers, input register.
// Depends on dsf_pkg, dsf_mapper, dsf_emitter.
//
//  channel | direction | handshake            | word
//  req     | in        | req_valid/req_stall  | req_type
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_type
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// A set-throttle word gives one status word; a send word gives 18 pulse-width
// words, one per cycle unless stalled, set by the emitter's slot counter.
// An accepted word goes via the input register into the emitter's registers.
// Synchronous active-high reset; csr_ready is always high.
// rsp_stall holds the output register; the input register fills behind it.
module dshot_frame_encoder
   import dsf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_word,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [PulseW-1:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   req_type item_ff, item_in;
   logic    item_valid_ff, item_valid_in;
   logic    can_load, advance;
   job_type job;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_IDLE_FLOOR:  cfg_in.idle_floor        = csr_wdata[ThrW-1:0];
            CSR_THR_CEILING: cfg_in.throttle_ceiling  = csr_wdata[ThrW-1:0];
            CSR_IDLE_SPIN:   cfg_in.idle_spin_mode    = csr_wdata[0];
            CSR_TELEMETRY:   cfg_in.telemetry_request = csr_wdata[0];
            CSR_PULSE_HIGH:  cfg_in.pulse_high        = csr_wdata;
            CSR_PULSE_LOW:   cfg_in.pulse_low         = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end

      advance   = item_valid_ff && can_load;
      req_stall = item_valid_ff && !advance;

      item_in       = item_ff;
      item_valid_in = item_valid_ff && !advance;
      if (req_valid && !req_stall) begin
         item_in       = req_word;
         item_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_floor        <= 11'd50;
         cfg_ff.throttle_ceiling  <= 11'd2000;
         cfg_ff.idle_spin_mode    <= 1'b0;
         cfg_ff.telemetry_request <= 1'b0;
         cfg_ff.pulse_high        <= 16'd150;
         cfg_ff.pulse_low         <= 16'd75;
         item_valid_ff            <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         item_valid_ff <= item_valid_in;
      end
      item_ff <= item_in;
   end

   assign csr_ready = 1'b1;

   dsf_mapper u_mapper (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .item    (item_ff),
      .advance (advance),
      .job     (job)
   );

   dsf_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job       (job),
      .job_valid (item_valid_ff),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

`ifndef SYNTHESIS
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !item_valid_ff |-> !req_stall)
      else $error("stall with empty input register");
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !advance |=> item_valid_ff && $stable(item_ff))
      else $error("pending item lost");
   a_advance_loads: assert property (@(posedge clock) disable iff (reset)
      advance |-> can_load && item_valid_ff)
      else $error("advance without room");
`endif

endmodule

>>> tb/dsf_frame_checker.sv
// Checker for the DShot frame encoder: watches the req, rsp and csr channels,
// predicts the result words of every accepted request word and compares them.
// Depends on dsf_pkg.
`timescale 1ns / 1ps

module dsf_frame_checker
   import dsf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  req_type            req_word,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  rsp_type            rsp_word,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [PulseW-1:0]  csr_wdata,
   output int                 fail_count,
   output int                 pending,
   output int                 words_checked
);

   localparam int REPORT_CAP = 100;

   localparam cfg_type CFG_RESET = '{
      idle_floor:        11'd50,
      throttle_ceiling:  11'd2000,
      idle_spin_mode:    1'b0,
      telemetry_request: 1'b0,
      pulse_high:        16'd150,
      pulse_low:         16'd75
   };

   cfg_type         cfg = CFG_RESET;
   logic [ThrW-1:0] dshot_value = '0;
   rsp_type         expected_words[$];
   int              errors = 0;
   int              shown = 0;
   int              checked = 0;

   function automatic logic [ThrW-1:0] scale_throttle(logic [ThrW-1:0] thr, logic armed);
      int v;
      if (!armed || (thr == 0 && !cfg.idle_spin_mode))
         return '0;
      v = (thr < cfg.idle_floor) ? int'(cfg.idle_floor) : int'(thr);
      if (v > int'(cfg.throttle_ceiling))
         v = int'(cfg.throttle_ceiling);
      v = v + int'(VALUE_OFFSET);
      if (v > int'(VALUE_MAX))
         v = int'(VALUE_MAX);
      return v[ThrW-1:0];
   endfunction

   function automatic void encode_item(req_type w);
      logic [ThrW:0]     pkt;
      logic [3:0]        csum;
      logic [FrameW-1:0] frame;
      rsp_type           r;
      if (w.action == ACT_SET) begin
         r.kind        = KIND_STATUS;
         r.status      = ST_OK;
         r.pulse_width = '0;
         r.last        = 1'b1;
         if (w.throttle > THROTTLE_LIMIT)
            r.status = ST_REJECT;
         else
            dshot_value = scale_throttle(w.throttle, w.armed);
         expected_words.push_back(r);
      end else begin
         pkt   = {dshot_value, cfg.telemetry_request};
         csum  = pkt[3:0] ^ pkt[7:4] ^ pkt[11:8];
         frame = {pkt, csum};
         for (int i = 0; i <= SLOT_LAST; i++) begin
            r.kind   = KIND_PULSE;
            r.status = ST_OK;
            if (i < FRAME_BITS)
               r.pulse_width = frame[FrameW-1-i] ? cfg.pulse_high : cfg.pulse_low;
            else
               r.pulse_width = '0;
            r.last = (i == SLOT_LAST);
            expected_words.push_back(r);
         end
      end
   endfunction

   function automatic bit field_ok(string field, logic [PulseW-1:0] want,
                                   logic [PulseW-1:0] got);
      if (got === want)
         return 1'b1;
      if (shown < REPORT_CAP)
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      else if (shown == REPORT_CAP)
         $display("%0t: further mismatches not shown", $time);
      shown++;
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      bit      ok;
      if (reset) begin
         cfg         = CFG_RESET;
         dshot_value = '0;
         expected_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word, expected none, got %h", $time, rsp_word);
               errors++;
            end else begin
               want = expected_words.pop_front();
               ok = field_ok("kind", PulseW'(want.kind), PulseW'(rsp_word.kind));
               ok &= field_ok("status", PulseW'(want.status), PulseW'(rsp_word.status));
               ok &= field_ok("pulse_width", want.pulse_width, rsp_word.pulse_width);
               ok &= field_ok("last", PulseW'(want.last), PulseW'(rsp_word.last));
               if (!ok)
                  errors++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IDLE_FLOOR:  cfg.idle_floor        = csr_wdata[ThrW-1:0];
               CSR_THR_CEILING: cfg.throttle_ceiling  = csr_wdata[ThrW-1:0];
               CSR_IDLE_SPIN:   cfg.idle_spin_mode    = csr_wdata[0];
               CSR_TELEMETRY:   cfg.telemetry_request = csr_wdata[0];
               CSR_PULSE_HIGH:  cfg.pulse_high        = csr_wdata;
               CSR_PULSE_LOW:   cfg.pulse_low         = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            encode_item(req_word);
      end
      fail_count    <= errors;
      pending       <= expected_words.size();
      words_checked <= checked;
   end

endmodule

>>> tb/testbench.sv
// Top of the DShot frame encoder testbench: clock, reset, stimulus and verdict.
// Depends on dsf_pkg, dshot_frame_encoder and dsf_frame_checker.
`timescale 1ns / 1ps

module testbench;
   import dsf_pkg::*;

   localparam int PHASES          = 4;
   localparam int PHASE_ITEMS     = 42;
   localparam int PRESSURE_FRAMES = 12;
   localparam int LONG_HOLD       = 150;
   localparam int SETTLE_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT  = 2000;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_type            req_word = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_word;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [PulseW-1:0]  csr_wdata = '0;

   int fail_count;
   int pending;
   int words_checked;

   logic quiet = 1'b0;
   logic hold_off = 1'b0;
   bit   burst = 1'b0;

   logic [ThrW-1:0] idle_v = 11'd50;
   logic [ThrW-1:0] max_v = 11'd2000;
   int n_set = 0;
   int n_reject = 0;
   int n_frame = 0;
   int n_csr = 0;

   dshot_frame_encoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dsf_frame_checker frame_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word      (rsp_word),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .words_checked (words_checked)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // returns at the edge that accepts the word, valid still high
   task automatic send_word(logic action, logic [ThrW-1:0] thr, logic armed);
      req_type w;
      int      gap;
      w.action   = action;
      w.throttle = thr;
      w.armed    = armed;
      if (!quiet && !burst && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (action == ACT_SEND)
         n_frame++;
      else if (thr > THROTTLE_LIMIT)
         n_reject++;
      else
         n_set++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CsrIdxW-1:0] idx, logic [PulseW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      n_csr++;
   endtask

   function automatic logic [ThrW-1:0] pick_limit();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return THROTTLE_LIMIT;
         2: return VALUE_MAX;
         default: return ThrW'($urandom_range(0, THROTTLE_LIMIT));
      endcase
   endfunction

   function automatic logic [PulseW-1:0] pick_pulse();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return PulseW'($urandom);
      endcase
   endfunction

   function automatic logic [ThrW-1:0] pick_throttle();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return THROTTLE_LIMIT;
         2: return (idle_v <= THROTTLE_LIMIT) ? idle_v : THROTTLE_LIMIT;
         3: return (max_v <= THROTTLE_LIMIT) ? max_v : THROTTLE_LIMIT;
         default: return ThrW'($urandom_range(0, THROTTLE_LIMIT));
      endcase
   endfunction

   // upper bits of narrow registers get junk; only the low bits land
   task automatic shuffle_config();
      logic [PulseW-1:0] junk;
      if ($urandom_range(0, 1))
         csr_write(CsrIdxW'($urandom), PulseW'($urandom));
      idle_v = pick_limit();
      max_v  = pick_limit();
      junk = $urandom;
      csr_write(CSR_IDLE_FLOOR, {junk[PulseW-1:ThrW], idle_v});
      junk = $urandom;
      csr_write(CSR_THR_CEILING, {junk[PulseW-1:ThrW], max_v});
      junk = $urandom;
      csr_write(CSR_IDLE_SPIN, {junk[PulseW-1:1], 1'($urandom)});
      junk = $urandom;
      csr_write(CSR_TELEMETRY, {junk[PulseW-1:1], 1'($urandom)});
      csr_write(CSR_PULSE_HIGH, pick_pulse());
      csr_write(CSR_PULSE_LOW, pick_pulse());
   endtask

   initial begin : rsp_side
      int n;
      bit long_done;
      long_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off && !long_done) begin
            long_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && !reset && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 12);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("testbench failed");
      $finish;
   end

   initial begin : stimulus
      int r;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero value, clamps, out-of-range rejects
      send_word(ACT_SEND, '1, 1'b1);
      send_word(ACT_SET, 11'd0, 1'b1);
      send_word(ACT_SET, 11'd2000, 1'b1);
      send_word(ACT_SEND, '0, 1'b0);
      send_word(ACT_SET, 11'd2001, 1'b1);
      send_word(ACT_SEND, 11'd1234, 1'b1);
      send_word(ACT_SET, 11'd2047, 1'b0);
      send_word(ACT_SET, 11'd1, 1'b1);
      send_word(ACT_SEND, '0, 1'b0);
      send_word(ACT_SET, 11'd1234, 1'b0);

      // idle above max, idle spin, telemetry bit, extreme pulse values
      settle();
      csr_write(CSR_IDLE_FLOOR, 16'd300);
      csr_write(CSR_THR_CEILING, 16'd200);
      csr_write(CSR_IDLE_SPIN, 16'd1);
      csr_write(CSR_TELEMETRY, 16'd1);
      csr_write(CSR_PULSE_HIGH, 16'hFFFF);
      csr_write(CSR_PULSE_LOW, 16'h0000);
      send_word(ACT_SET, 11'd0, 1'b1);
      send_word(ACT_SEND, '0, 1'b0);
      send_word(ACT_SET, 11'd2000, 1'b1);
      send_word(ACT_SET, 11'd0, 1'b0);

      // saturation of the mapped value
      settle();
      csr_write(CSR_IDLE_FLOOR, 16'hFFFF);
      csr_write(CSR_THR_CEILING, 16'hFFFF);
      send_word(ACT_SET, 11'd1000, 1'b1);
      send_word(ACT_SEND, '1, 1'b1);

      // zero clamps
      settle();
      csr_write(CSR_IDLE_FLOOR, 16'd0);
      csr_write(CSR_THR_CEILING, 16'd0);
      csr_write(CSR_PULSE_HIGH, 16'h0000);
      csr_write(CSR_PULSE_LOW, 16'hFFFF);
      send_word(ACT_SET, 11'd1, 1'b1);
      send_word(ACT_SEND, '0, 1'b1);
      settle();
      csr_write(CSR_IDLE_SPIN, 16'd0);
      send_word(ACT_SET, 11'd0, 1'b1);
      send_word(ACT_SEND, '1, 1'b0);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         shuffle_config();
         if (p == PHASES - 1)
            quiet <= 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 1 && k == 10) begin
               // output held off while frames keep coming in
               hold_off <= 1'b1;
               burst = 1'b1;
               repeat (PRESSURE_FRAMES) send_word(ACT_SEND, ThrW'($urandom), 1'($urandom));
               burst = 1'b0;
            end
            r = $urandom_range(0, 9);
            if (r < 5)
               send_word(ACT_SET, pick_throttle(), $urandom_range(0, 3) != 0);
            else if (r == 5)
               send_word(ACT_SET, ThrW'($urandom_range(THROTTLE_LIMIT + 1, VALUE_MAX)),
                         1'($urandom));
            else
               send_word(ACT_SEND, ThrW'($urandom), 1'($urandom));
         end
      end

      settle();
      $display("covered %0d throttle updates, %0d out-of-range requests, %0d frames",
               n_set, n_reject, n_frame);
      $display("with %0d register writes; %0d result words compared", n_csr, words_checked);
      if (fail_count == 0 && pending == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
